[hw/rtl/spa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types, widths and constants for the swaption path payoff averager.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Field widths
  localparam int RATE_W     = 22;
  localparam int Q30_W      = 30;
  localparam int NOTIONAL_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int PAYOFF_W   = 50;
  localparam int SUM_W      = 64;
  localparam int COUNT_BITS_DEFAULT = 16;

  // Discount factor divider: 2^30 * 400 * 2^16 / (400 * 2^16 + R * k)
  localparam int DF_NUM_W  = 55;
  localparam int DF_DEN_W  = 26;
  localparam int DF_W      = 31;
  localparam int QTR_W     = 3;
  localparam int DF_PROD_W = RATE_W + QTR_W;
  localparam logic [DF_DEN_W-1:0] DF_BASE = 26'd26214400;
  localparam logic [DF_NUM_W-1:0] DF_NUM  = 55'd28147497671065600;

  // Swap rate divider: (2^30 - DF4) << 30 / annuity
  localparam int SWAP_NUM_W = 60;
  localparam logic [DF_W-1:0] ONE_Q30 = 31'h4000_0000;

  // Configuration register indexes
  localparam logic [0:0] CFG_STRIKE   = 1'b0;
  localparam logic [0:0] CFG_NOTIONAL = 1'b1;
  localparam logic [Q30_W-1:0]      STRIKE_RESET   = 30'd50465865;
  localparam logic [NOTIONAL_W-1:0] NOTIONAL_RESET = 32'd1000000;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DF,
    S_SWAP_GO,
    S_SWAP,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_MEAN,
    S_EMIT
  } state_t;

  // Control from the sequencer to the merge datapath
  typedef struct packed {
    logic df_load;
    logic swap_start;
    logic mul1_en;
    logic mul2_en;
    logic acc_en;
  } merge_ctl_t;

  // Status from the merge datapath back to the sequencer
  typedef struct packed {
    logic swap_done;
    logic mean_done;
  } merge_sts_t;

endpackage

[hw/rtl/spa_divu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_divu
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spa_divu #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    trial   = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[hw/rtl/spa_df_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_df_lane
// One discount factor lane: forms the denominator for its quarter and divides.
// ----------------------------------------------------------------------------
module spa_df_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [spa_pkg::RATE_W-1:0] rate,
  input  logic [spa_pkg::QTR_W-1:0]  quarter,
  output logic                       done,
  output logic [spa_pkg::DF_W-1:0]   df
);

  logic [spa_pkg::DF_PROD_W-1:0] prod;
  logic [spa_pkg::DF_DEN_W-1:0]  den;
  logic [spa_pkg::DF_NUM_W-1:0]  quo;

  // Denominator 400 * 2^16 + R * k.
  assign prod = spa_pkg::DF_PROD_W'(rate) * spa_pkg::DF_PROD_W'(quarter);
  assign den  = spa_pkg::DF_BASE + spa_pkg::DF_DEN_W'(prod);

  spa_divu #(
    .NUM_W(spa_pkg::DF_NUM_W),
    .DEN_W(spa_pkg::DF_DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .num  (spa_pkg::DF_NUM),
    .den  (den),
    .done (done),
    .quo  (quo)
  );

  // The factor never exceeds 2^30, so the low bits carry it.
  assign df = quo[spa_pkg::DF_W-1:0];

endmodule

[hw/rtl/spa_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_merge
// Merge stage: annuity, swap rate, payoff, batch sum and count, batch mean.
// ----------------------------------------------------------------------------
module spa_merge #(
  parameter int COUNT_BITS = spa_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spa_pkg::merge_ctl_t            ctl,
  input  logic [3:0][spa_pkg::DF_W-1:0]  df,
  input  logic [spa_pkg::Q30_W-1:0]      strike,
  input  logic [spa_pkg::NOTIONAL_W-1:0] notional,
  input  logic                           last,
  output spa_pkg::merge_sts_t            sts,
  output logic [spa_pkg::Q30_W-1:0]      swap_rate,
  output logic [spa_pkg::PAYOFF_W-1:0]   payoff,
  output logic [spa_pkg::PAYOFF_W-1:0]   mean,
  output logic                           sat
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [spa_pkg::DF_W-1:0]       annuity_r;
  logic [spa_pkg::Q30_W-1:0]      one_minus_r;
  logic                           swap_zero_r;
  logic [spa_pkg::Q30_W-1:0]      swap_r;
  logic [spa_pkg::DF_W-1:0]       t_r;
  logic [spa_pkg::PAYOFF_W-2:0]   payoff_r;
  logic [spa_pkg::SUM_W-1:0]      sum_r;
  logic [COUNT_BITS-1:0]          cnt_r;
  logic                           sat_r;
  logic [spa_pkg::PAYOFF_W-1:0]   mean_r;

  logic [spa_pkg::DF_W+1:0]       df_sum;
  logic                           swap_done;
  logic [spa_pkg::SWAP_NUM_W-1:0] swap_quo;
  logic [spa_pkg::Q30_W-1:0]      diff;
  logic [2*spa_pkg::DF_W-1:0]     prod1;
  logic [spa_pkg::DF_W+spa_pkg::NOTIONAL_W-1:0] prod2;
  logic [spa_pkg::SUM_W:0]        sum_add;
  logic [spa_pkg::SUM_W-1:0]      sum_new;
  logic [COUNT_BITS-1:0]          cnt_new;
  logic                           mean_start;
  logic                           mean_done;
  logic [spa_pkg::SUM_W-1:0]      mean_quo;

  // Annuity is the quarter sum of the four lane factors.
  assign df_sum = (spa_pkg::DF_W+2)'(df[0]) + (spa_pkg::DF_W+2)'(df[1])
                + (spa_pkg::DF_W+2)'(df[2]) + (spa_pkg::DF_W+2)'(df[3]);

  always_ff @(posedge clk) begin
    if (ctl.df_load) begin
      annuity_r   <= df_sum[spa_pkg::DF_W+1:2];
      one_minus_r <= spa_pkg::Q30_W'(spa_pkg::ONE_Q30 - df[3]);
      swap_zero_r <= (df_sum[spa_pkg::DF_W+1:2] == '0) || (df[3] >= spa_pkg::ONE_Q30);
    end
  end

  // Swap rate division.
  spa_divu #(
    .NUM_W(spa_pkg::SWAP_NUM_W),
    .DEN_W(spa_pkg::DF_W)
  ) u_swap_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(ctl.swap_start),
    .num  ({one_minus_r, {spa_pkg::Q30_W{1'b0}}}),
    .den  (annuity_r),
    .done (swap_done),
    .quo  (swap_quo)
  );

  // Capture the swap rate, saturated to the Q0.30 range; zero if the annuity is zero or DF4 reaches one.
  always_ff @(posedge clk) begin
    if (swap_done) begin
      if (swap_zero_r) begin
        swap_r <= '0;
      end else if (swap_quo[spa_pkg::SWAP_NUM_W-1:spa_pkg::Q30_W] != '0) begin
        swap_r <= '1;
      end else begin
        swap_r <= swap_quo[spa_pkg::Q30_W-1:0];
      end
    end
  end

  // Payoff: excess over strike times annuity, then times notional.
  assign diff  = (swap_r > strike) ? swap_r - strike : '0;
  assign prod1 = (2*spa_pkg::DF_W)'(diff) * (2*spa_pkg::DF_W)'(annuity_r);
  assign prod2 = (spa_pkg::DF_W+spa_pkg::NOTIONAL_W)'(t_r)
               * (spa_pkg::DF_W+spa_pkg::NOTIONAL_W)'(notional);

  always_ff @(posedge clk) begin
    if (ctl.mul1_en) begin
      t_r <= prod1[2*spa_pkg::DF_W-2:spa_pkg::Q30_W];
    end
    if (ctl.mul2_en) begin
      payoff_r <= prod2[spa_pkg::DF_W+spa_pkg::NOTIONAL_W-1:14];
    end
  end

  // Saturating batch sum and count.
  always_comb begin
    sum_add = {1'b0, sum_r} + (spa_pkg::SUM_W+1)'(payoff_r);
    if (cnt_r != CNT_MAX) begin
      sum_new = sum_add[spa_pkg::SUM_W] ? '1 : sum_add[spa_pkg::SUM_W-1:0];
      cnt_new = cnt_r + COUNT_BITS'(1);
    end else begin
      sum_new = sum_r;
      cnt_new = cnt_r;
    end
  end

  assign mean_start = ctl.acc_en && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      sat_r <= 1'b0;
    end else if (ctl.acc_en) begin
      sat_r <= (cnt_new == CNT_MAX);
      if (last) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_new;
        cnt_r <= cnt_new;
      end
    end
  end

  // Batch mean division, started only on the last path.
  spa_divu #(
    .NUM_W(spa_pkg::SUM_W),
    .DEN_W(COUNT_BITS)
  ) u_mean_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mean_start),
    .num  (sum_new),
    .den  (cnt_new),
    .done (mean_done),
    .quo  (mean_quo)
  );

  always_ff @(posedge clk) begin
    if (ctl.acc_en && !last) begin
      mean_r <= '0;
    end else if (mean_done) begin
      mean_r <= mean_quo[spa_pkg::PAYOFF_W-1:0];
    end
  end

  assign sts.swap_done = swap_done;
  assign sts.mean_done = mean_done;
  assign swap_rate     = swap_r;
  assign payoff        = spa_pkg::PAYOFF_W'(payoff_r);
  assign mean          = mean_r;
  assign sat           = sat_r;

endmodule

[hw/rtl/swaption_path_payoff_averager_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swaption_path_payoff_averager_core
// Payer swaption payoff per simulated rate path, with a running batch mean.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one rate path per transaction (four quarterly
//   rates and a last flag). The output channel returns one transaction per
//   path: swap rate, path payoff, and on the last path the batch mean.
//   Four lanes compute the quarterly discount factors at once with bit-serial
//   dividers; the merge stage then runs the swap rate divider, two multiply
//   stages and the accumulate step. A path's result is offered after the
//   accumulate step; a last path first runs the batch mean division and
//   captures the mean. One path is in work at a time and the next one is
//   accepted in the cycle after the result is registered.
//   The next path is accepted as soon as the result sits in the output
//   register, even while the receiver stalls it; a finished result waits in
//   the merge stage until the output register is free.
//   Reset clears the sequencer, the output valid flag, the batch sum, count
//   and saturation flag, and restores the default strike and notional.
//   Configuration is to be written by the user only while idle; the block
//   itself does not enforce it.
// ----------------------------------------------------------------------------
module swaption_path_payoff_averager_core #(
  parameter int COUNT_BITS = spa_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [spa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spa_pkg::RATE_W-1:0]     in_rate_q1,
  input  logic [spa_pkg::RATE_W-1:0]     in_rate_q2,
  input  logic [spa_pkg::RATE_W-1:0]     in_rate_q3,
  input  logic [spa_pkg::RATE_W-1:0]     in_rate_q4,
  input  logic                           in_last_path,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spa_pkg::Q30_W-1:0]      out_swap_rate,
  output logic [spa_pkg::PAYOFF_W-1:0]   out_path_payoff,
  output logic [spa_pkg::PAYOFF_W-1:0]   out_mean_price,
  output logic                           out_price_valid,
  output logic                           out_count_saturated
);

  spa_pkg::state_t state_r, state_nxt;

  logic [spa_pkg::Q30_W-1:0]      strike_r;
  logic [spa_pkg::NOTIONAL_W-1:0] notional_r;
  logic                           last_r;
  logic                           out_valid_r;
  logic [spa_pkg::Q30_W-1:0]      swap_out_r;
  logic [spa_pkg::PAYOFF_W-1:0]   payoff_out_r;
  logic [spa_pkg::PAYOFF_W-1:0]   mean_out_r;
  logic                           price_valid_r;
  logic                           sat_out_r;

  logic                           accept;
  logic                           emit;
  logic [3:0]                     lane_done;
  logic [3:0][spa_pkg::DF_W-1:0]  lane_df;
  logic [3:0][spa_pkg::RATE_W-1:0] lane_rate;
  spa_pkg::merge_ctl_t            ctl;
  spa_pkg::merge_sts_t            sts;
  logic [spa_pkg::Q30_W-1:0]      m_swap;
  logic [spa_pkg::PAYOFF_W-1:0]   m_payoff;
  logic [spa_pkg::PAYOFF_W-1:0]   m_mean;
  logic                           m_sat;

  assign in_stall = (state_r != spa_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign emit     = (state_r == spa_pkg::S_EMIT) && (!out_valid_r || !out_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strike_r   <= spa_pkg::STRIKE_RESET;
      notional_r <= spa_pkg::NOTIONAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spa_pkg::CFG_STRIKE:   strike_r   <= cfg_wdata[spa_pkg::Q30_W-1:0];
        spa_pkg::CFG_NOTIONAL: notional_r <= cfg_wdata;
        default:               strike_r   <= strike_r;
      endcase
    end
  end

  // Last flag of the path in work.
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last_path;
    end
  end

  // Discount factor lanes, one per quarter.
  assign lane_rate[0] = in_rate_q1;
  assign lane_rate[1] = in_rate_q2;
  assign lane_rate[2] = in_rate_q3;
  assign lane_rate[3] = in_rate_q4;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    spa_df_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (accept),
      .rate   (lane_rate[g]),
      .quarter(spa_pkg::QTR_W'(g + 1)),
      .done   (lane_done[g]),
      .df     (lane_df[g])
    );
  end

  spa_merge #(
    .COUNT_BITS(COUNT_BITS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .df       (lane_df),
    .strike   (strike_r),
    .notional (notional_r),
    .last     (last_r),
    .sts      (sts),
    .swap_rate(m_swap),
    .payoff   (m_payoff),
    .mean     (m_mean),
    .sat      (m_sat)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spa_pkg::S_IDLE:    if (accept) state_nxt = spa_pkg::S_DF;
      spa_pkg::S_DF:      if (&lane_done) state_nxt = spa_pkg::S_SWAP_GO;
      spa_pkg::S_SWAP_GO: state_nxt = spa_pkg::S_SWAP;
      spa_pkg::S_SWAP:    if (sts.swap_done) state_nxt = spa_pkg::S_MUL1;
      spa_pkg::S_MUL1:    state_nxt = spa_pkg::S_MUL2;
      spa_pkg::S_MUL2:    state_nxt = spa_pkg::S_ACC;
      spa_pkg::S_ACC:     state_nxt = last_r ? spa_pkg::S_MEAN : spa_pkg::S_EMIT;
      spa_pkg::S_MEAN:    if (sts.mean_done) state_nxt = spa_pkg::S_EMIT;
      spa_pkg::S_EMIT:    if (emit) state_nxt = spa_pkg::S_IDLE;
      default:            state_nxt = spa_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctl            = '0;
    ctl.df_load    = (state_r == spa_pkg::S_DF) && (&lane_done);
    ctl.swap_start = (state_r == spa_pkg::S_SWAP_GO);
    ctl.mul1_en    = (state_r == spa_pkg::S_MUL1);
    ctl.mul2_en    = (state_r == spa_pkg::S_MUL2);
    ctl.acc_en     = (state_r == spa_pkg::S_ACC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      swap_out_r    <= m_swap;
      payoff_out_r  <= m_payoff;
      mean_out_r    <= m_mean;
      price_valid_r <= last_r;
      sat_out_r     <= m_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_swap_rate       = swap_out_r;
  assign out_path_payoff     = payoff_out_r;
  assign out_mean_price      = mean_out_r;
  assign out_price_valid     = price_valid_r;
  assign out_count_saturated = sat_out_r;

endmodule
